// ===== hdl/byte_cpu_bus_cycle_core_assert.svh =====
// assertion macros shared by the checker
`ifndef BYTE_CPU_BUS_CYCLE_CORE_ASSERT_SVH
`define BYTE_CPU_BUS_CYCLE_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define BCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/bcc_pkg.sv =====
package bcc_pkg;

    localparam int unsigned DataW = 8;
    localparam int unsigned AddrW = 32;
    localparam logic [AddrW-1:0] SpReset = 32'h003F_FFFF;
    localparam logic [AddrW-1:0] IrqVecReset = '0;
    localparam int unsigned PaddrW = 2;

    localparam logic [7:0] FlgC = 8'h01;
    localparam logic [7:0] FlgZ = 8'h02;

    localparam logic [2:0] PushIrqCnt = 3'd5;
    localparam logic [2:0] PushCallCnt = 3'd4;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_FETCH = 4'd1,
        PH_IDX0  = 4'd2,
        PH_IDX1  = 4'd3,
        PH_ADDR0 = 4'd4,
        PH_ADDR1 = 4'd5,
        PH_ADDR2 = 4'd6,
        PH_ADDR3 = 4'd7,
        PH_MEM   = 4'd8,
        PH_PUSH  = 4'd9,
        PH_POP   = 4'd10,
        PH_DIV   = 4'd11
    } t_phase;

    typedef enum logic [7:0] {
        OP_LDI   = 8'h01, OP_LDM  = 8'h02, OP_STM  = 8'h03, OP_ADD = 8'h04,
        OP_SUB   = 8'h05, OP_CMP  = 8'h06, OP_JMP  = 8'h07, OP_JZ  = 8'h08,
        OP_JNZ   = 8'h09, OP_PUSH = 8'h0A, OP_POP  = 8'h0B, OP_CALL = 8'h0C,
        OP_RET   = 8'h0D, OP_EI   = 8'h0E, OP_DI   = 8'h0F, OP_RETI = 8'h10,
        OP_LDHL  = 8'h11, OP_STHL = 8'h12, OP_LDAHL = 8'h13, OP_INCHL = 8'h14,
        OP_DECHL = 8'h15, OP_MUL  = 8'h16, OP_DIV  = 8'h17, OP_MOD = 8'h18,
        OP_AND   = 8'h19, OP_OR   = 8'h1A, OP_XOR  = 8'h1B, OP_NOT = 8'h1C,
        OP_SHL   = 8'h1D, OP_SHR  = 8'h1E, OP_ADC  = 8'h1F, OP_SBC = 8'h20,
        OP_JC    = 8'h21, OP_JNC  = 8'h22, OP_ADDHL = 8'h23, OP_HLT = 8'hFF
    } t_opcode;

    typedef enum logic [0:0] {
        REG_IRQ_VEC = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic start;
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic [DataW-1:0] quot;
        logic [DataW-1:0] rem;
    } t_div_rsp;

endpackage

// ===== hdl/bcc_chan_if.sv =====
interface bcc_chan_if #(
    parameter int unsigned PayloadW = 9
) (
    input logic i_clk
);
    logic valid;
    logic ready;
    logic [PayloadW-1:0] payload;

    modport source (input i_clk, output valid, output payload, input ready);
    modport sink (input i_clk, input valid, input payload, output ready);
endinterface

// ===== hdl/bcc_divider.sv =====
module bcc_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcc_pkg::t_div_req i_req,
    output bcc_pkg::t_div_rsp o_rsp
);
    import bcc_pkg::*;

    localparam int unsigned CntW = $clog2(DataW + 1);

    logic [DataW-1:0] r_quot, n_quot;
    logic [DataW-1:0] r_rem, n_rem;
    logic [DataW-1:0] r_dvs, n_dvs;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DataW:0]   trial;

    // restoring divide, one quotient bit a cycle
    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quot[DataW-1]} - {1'b0, r_dvs};
        if (i_req.start) begin
            n_quot = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = CntW'(DataW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial[DataW]) begin
                n_rem = {r_rem[DataW-2:0], r_quot[DataW-1]};
                n_quot = {r_quot[DataW-2:0], 1'b0};
            end else begin
                n_rem = trial[DataW-1:0];
                n_quot = {r_quot[DataW-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;
endmodule

// ===== hdl/bcc_cfg_regs.sv =====
module bcc_cfg_regs #(
    parameter logic [31:0] IrqVecInit = bcc_pkg::IrqVecReset
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bcc_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [31:0]                o_irq_vec
);
    import bcc_pkg::*;

    logic [31:0] r_irq_vec;
    logic        wr_en;
    logic        hit;

    assign hit   = (paddr == PaddrW'({REG_IRQ_VEC, 2'b00}));
    assign wr_en = psel && penable && pwrite && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_vec <= IrqVecInit;
        end else if (wr_en) begin
            r_irq_vec <= pwdata;
        end
    end

    assign prdata    = hit ? r_irq_vec : '0;
    assign pready    = 1'b1;
    assign o_irq_vec = r_irq_vec;
endmodule

// ===== hdl/bcc_sequencer.sv =====
module bcc_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [bcc_pkg::DataW-1:0]       i_rd,
    input  logic                            i_irq,
    input  logic [bcc_pkg::AddrW-1:0]       i_irq_vec,
    input  bcc_pkg::t_div_rsp               i_div,
    output bcc_pkg::t_div_req               o_div,
    output logic                            o_stall,
    output logic [bcc_pkg::AddrW-1:0]       o_addr,
    output logic [bcc_pkg::DataW-1:0]       o_wdata,
    output logic                            o_wr,
    output logic                            o_valid,
    output logic                            o_halted,
    output logic                            o_done
);
    import bcc_pkg::*;

    logic [7:0]       r_rf [4], n_rf [4];
    logic [AddrW-1:0] r_pc, n_pc, r_sp, n_sp, r_hl, n_hl, r_opnd, n_opnd;
    logic [7:0]       r_flg, n_flg, r_op, n_op, r_i0, n_i0, r_i1, n_i1;
    logic             r_ie, n_ie, r_halt, n_halt;
    logic             r_irq, n_irq;
    t_phase           r_ph, n_ph;

    logic [AddrW-1:0] b_addr;
    logic [7:0]       b_data, ra, rr, ps_byte;
    logic             b_wr, b_valid, b_done, want_begin, alu_div, irq_now;
    logic [8:0]       s9;
    logic [15:0]      off;
    logic [15:0]      prod;
    logic [1:0]       kk;
    logic [7:0]       nc;

    assign o_stall = (r_ph == PH_DIV);

    always_comb begin
        for (int i = 0; i < 4; i++) n_rf[i] = r_rf[i];
        n_pc = r_pc; n_sp = r_sp; n_hl = r_hl; n_opnd = r_opnd;
        n_flg = r_flg; n_op = r_op; n_i0 = r_i0; n_i1 = r_i1;
        n_ie = r_ie; n_halt = r_halt; n_ph = r_ph; n_irq = r_irq;
        b_addr = '0; b_data = '0; b_wr = 1'b0; b_valid = 1'b0; b_done = 1'b0;
        want_begin = 1'b0; alu_div = 1'b0;
        o_div.start = 1'b0; o_div.dividend = r_rf[0]; o_div.divisor = '0;
        ra = r_rf[0]; rr = '0; s9 = '0; off = '0; prod = '0; ps_byte = '0;
        kk = '0; nc = '0;
        // interrupt line of the divide request is held while the divider runs
        irq_now = (r_ph == PH_DIV) ? r_irq : i_irq;

        if (r_ph == PH_DIV) begin
            // divider result lands, finish the ALU op
            if (i_div.done) begin
                n_rf[0] = (r_op == OP_MOD) ? i_div.rem : i_div.quot;
                b_done = 1'b1;
                want_begin = 1'b1;
            end
        end else if (i_step && !r_halt) begin
            case (r_ph)
                PH_FETCH: begin
                    n_op = i_rd;
                    case (i_rd)
                        OP_LDI, OP_ADD, OP_SUB, OP_CMP, OP_PUSH, OP_POP, OP_MUL, OP_DIV,
                        OP_MOD, OP_AND, OP_OR, OP_XOR, OP_ADC, OP_SBC, OP_ADDHL: begin
                            b_addr = r_pc; b_valid = 1'b1; n_pc = r_pc + 1'b1;
                            n_ph = PH_IDX0;
                        end
                        OP_LDM, OP_STM, OP_JMP, OP_JZ, OP_JNZ, OP_CALL, OP_LDHL,
                        OP_JC, OP_JNC: begin
                            n_opnd = '0;
                            b_addr = r_pc; b_valid = 1'b1; n_pc = r_pc + 1'b1;
                            n_ph = PH_ADDR0;
                        end
                        OP_RET, OP_RETI: begin
                            n_i0 = (i_rd == OP_RETI) ? 8'd5 : 8'd4;
                            n_i1 = '0; n_opnd = '0;
                            n_sp = r_sp + 1'b1; b_addr = r_sp + 1'b1; b_valid = 1'b1;
                            n_ph = PH_POP;
                        end
                        OP_EI: begin n_ie = 1'b1; b_done = 1'b1; want_begin = 1'b1; end
                        OP_DI: begin n_ie = 1'b0; b_done = 1'b1; want_begin = 1'b1; end
                        OP_STHL: begin
                            b_addr = r_hl; b_data = r_rf[0]; b_wr = 1'b1; b_valid = 1'b1;
                            b_done = 1'b1; n_ph = PH_START;
                        end
                        OP_LDAHL: begin b_addr = r_hl; b_valid = 1'b1; n_ph = PH_MEM; end
                        OP_INCHL: begin n_hl = r_hl + 1'b1; b_done = 1'b1; want_begin = 1'b1; end
                        OP_DECHL: begin n_hl = r_hl - 1'b1; b_done = 1'b1; want_begin = 1'b1; end
                        OP_NOT: begin n_rf[0] = ~r_rf[0]; b_done = 1'b1; want_begin = 1'b1; end
                        OP_SHL: begin
                            n_rf[0] = {r_rf[0][6:0], 1'b0}; b_done = 1'b1; want_begin = 1'b1;
                        end
                        OP_SHR: begin
                            n_rf[0] = {1'b0, r_rf[0][7:1]}; b_done = 1'b1; want_begin = 1'b1;
                        end
                        default: begin n_halt = 1'b1; b_done = 1'b1; n_ph = PH_START; end
                    endcase
                end
                PH_IDX0: begin
                    n_i0 = i_rd;
                    if (r_op == OP_LDI || r_op == OP_ADDHL) begin
                        b_addr = r_pc; b_valid = 1'b1; n_pc = r_pc + 1'b1; n_ph = PH_IDX1;
                    end else if (r_op == OP_PUSH && i_rd < 8'd4) begin
                        b_addr = r_sp; b_data = r_rf[i_rd[1:0]]; b_wr = 1'b1; b_valid = 1'b1;
                        n_sp = r_sp - 1'b1; b_done = 1'b1; n_ph = PH_START;
                    end else if (r_op == OP_POP && i_rd < 8'd4) begin
                        n_sp = r_sp + 1'b1; b_addr = r_sp + 1'b1; b_valid = 1'b1;
                        n_ph = PH_MEM;
                    end else begin
                        want_begin = 1'b1; b_done = 1'b1;
                        if (i_rd < 8'd4 && r_op != OP_PUSH && r_op != OP_POP) begin
                            rr = r_rf[i_rd[1:0]];
                            case (r_op)
                                OP_ADD, OP_ADC: begin
                                    s9 = {1'b0, ra} + {1'b0, rr}
                                        + ((r_op == OP_ADC) ? {8'd0, r_flg[0]} : 9'd0);
                                    n_rf[0] = s9[7:0];
                                    n_flg[0] = s9[8];
                                end
                                OP_SUB, OP_SBC: begin
                                    s9 = {1'b0, rr}
                                        + ((r_op == OP_SBC) ? {8'd0, r_flg[0]} : 9'd0);
                                    n_flg[0] = ({1'b0, ra} < s9);
                                    n_rf[0] = ra - s9[7:0];
                                end
                                OP_CMP: begin
                                    n_flg[1] = (ra == rr);
                                    n_flg[0] = (ra < rr);
                                end
                                OP_MUL: begin prod = ra * rr; n_rf[0] = prod[7:0]; end
                                OP_DIV, OP_MOD: begin
                                    if (rr != 8'd0) begin
                                        alu_div = 1'b1;
                                        o_div.start = 1'b1;
                                        o_div.divisor = rr;
                                    end
                                end
                                OP_AND: n_rf[0] = ra & rr;
                                OP_OR:  n_rf[0] = ra | rr;
                                OP_XOR: n_rf[0] = ra ^ rr;
                                default: ;
                            endcase
                        end
                    end
                end
                PH_IDX1: begin
                    if (r_op == OP_LDI) begin
                        if (r_i0 < 8'd4) n_rf[r_i0[1:0]] = i_rd;
                    end else begin
                        if (r_i0 < 8'd4) off[15:8] = r_rf[r_i0[1:0]];
                        if (i_rd < 8'd4) off[7:0] = r_rf[i_rd[1:0]];
                        n_hl = r_hl + {16'd0, off};
                    end
                    b_done = 1'b1; want_begin = 1'b1;
                end
                PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
                    kk = r_ph[1:0];
                    n_opnd = r_opnd | ({24'd0, i_rd} << {kk, 3'b000});
                    if (kk != 2'd3) begin
                        b_addr = r_pc; b_valid = 1'b1; n_pc = r_pc + 1'b1;
                        n_ph = t_phase'(r_ph + 1'b1);
                    end else begin
                        case (r_op)
                            OP_LDM: begin b_addr = n_opnd; b_valid = 1'b1; n_ph = PH_MEM; end
                            OP_STM: begin
                                b_addr = n_opnd; b_data = r_rf[0]; b_wr = 1'b1;
                                b_valid = 1'b1; b_done = 1'b1; n_ph = PH_START;
                            end
                            OP_CALL: begin
                                b_addr = r_sp; b_data = r_pc[31:24]; b_wr = 1'b1;
                                b_valid = 1'b1; n_sp = r_sp - 1'b1;
                                n_i0 = 8'd4; n_i1 = 8'd1; n_ph = PH_PUSH;
                            end
                            default: begin
                                case (r_op)
                                    OP_JMP: n_pc = n_opnd;
                                    OP_JZ:  if (r_flg[1]) n_pc = n_opnd;
                                    OP_JNZ: if (!r_flg[1]) n_pc = n_opnd;
                                    OP_JC:  if (r_flg[0]) n_pc = n_opnd;
                                    OP_JNC: if (!r_flg[0]) n_pc = n_opnd;
                                    OP_LDHL: n_hl = n_opnd;
                                    default: ;
                                endcase
                                b_done = 1'b1; want_begin = 1'b1;
                            end
                        endcase
                    end
                end
                PH_MEM: begin
                    if (r_op == OP_POP) n_rf[r_i0[1:0]] = i_rd;
                    else n_rf[0] = i_rd;
                    b_done = 1'b1; want_begin = 1'b1;
                end
                PH_PUSH: begin
                    case (r_i1[2:0])
                        3'd0: ps_byte = r_pc[31:24];
                        3'd1: ps_byte = r_pc[23:16];
                        3'd2: ps_byte = r_pc[15:8];
                        3'd3: ps_byte = r_pc[7:0];
                        default: ps_byte = r_flg;
                    endcase
                    b_addr = r_sp; b_data = ps_byte; b_wr = 1'b1; b_valid = 1'b1;
                    n_sp = r_sp - 1'b1;
                    nc = r_i1 + 1'b1; n_i1 = nc;
                    if (nc >= r_i0) begin
                        if (r_i0 == 8'd5) begin n_ie = 1'b0; n_pc = i_irq_vec; end
                        else n_pc = r_opnd;
                        b_done = 1'b1; n_ph = PH_START;
                    end
                end
                PH_POP: begin
                    if (r_i0 == 8'd5 && r_i1 == 8'd0) n_flg = i_rd;
                    else begin
                        kk = 2'(r_i1 - (r_i0 - 8'd4));
                        n_opnd = r_opnd | ({24'd0, i_rd} << {kk, 3'b000});
                    end
                    nc = r_i1 + 1'b1; n_i1 = nc;
                    if (nc >= r_i0) begin
                        n_pc = n_opnd;
                        if (r_op == OP_RETI) n_ie = 1'b1;
                        b_done = 1'b1; want_begin = 1'b1;
                    end else begin
                        n_sp = r_sp + 1'b1; b_addr = r_sp + 1'b1; b_valid = 1'b1;
                    end
                end
                default: want_begin = 1'b1;
            endcase
        end

        if (alu_div) begin
            n_ph = PH_DIV;
            n_irq = i_irq;
            b_done = 1'b0;
            want_begin = 1'b0;
        end else if (want_begin) begin
            // start of next instruction: interrupt entry or opcode fetch
            if (n_ie && irq_now) begin
                b_addr = n_sp; b_data = n_pc[31:24]; b_wr = 1'b1; b_valid = 1'b1;
                n_sp = n_sp - 1'b1; n_i0 = 8'd5; n_i1 = 8'd1; n_ph = PH_PUSH;
            end else begin
                b_addr = n_pc; b_valid = 1'b1; b_wr = 1'b0; b_data = '0;
                n_pc = n_pc + 1'b1; n_ph = PH_FETCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_rf[i] <= '0;
            r_pc <= '0; r_sp <= SpReset; r_hl <= '0; r_opnd <= '0;
            r_flg <= '0; r_op <= '0; r_i0 <= '0; r_i1 <= '0;
            r_ie <= 1'b0; r_halt <= 1'b0; r_ph <= PH_START; r_irq <= 1'b0;
        end else if (i_step || r_ph == PH_DIV) begin
            for (int i = 0; i < 4; i++) r_rf[i] <= n_rf[i];
            r_pc <= n_pc; r_sp <= n_sp; r_hl <= n_hl; r_opnd <= n_opnd;
            r_flg <= n_flg; r_op <= n_op; r_i0 <= n_i0; r_i1 <= n_i1;
            r_ie <= n_ie; r_halt <= n_halt; r_ph <= n_ph; r_irq <= n_irq;
        end
    end

    assign o_addr   = b_addr;
    assign o_wdata  = b_data;
    assign o_wr     = b_wr;
    assign o_valid  = b_valid;
    assign o_halted = n_halt;
    assign o_done   = b_done;
endmodule

// ===== hdl/byte_cpu_bus_cycle_core.sv =====
// channel   | dir | payload                                          | handshake
// in_ch     | in  | {irq_pending, read_data}                         | valid/ready
// out_ch    | out | {instr_done, halted, access_valid, is_write,     | valid/ready
//           |     |  write_data, bus_address}                        |
// apb       | in  | irq vector register at byte address 0            | psel/penable
//
// one request in gives one request out; most are accepted, then the result register
// holds the result until taken
// DIV and MOD occupy the shared restoring divider, then finish when it signals done
// input ready drops while a result waits or the divider runs
// synchronous active-low reset; after reset sp is 0x003fffff, the irq vector is IrqVecInit, other sequencer state zero
module byte_cpu_bus_cycle_core #(
    parameter logic [31:0] IrqVecInit = bcc_pkg::IrqVecReset
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    bcc_chan_if.sink                   in_ch,
    bcc_chan_if.source                 out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bcc_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bcc_pkg::*;

    logic [AddrW-1:0] irq_vec;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    logic             step, stall;
    logic [AddrW-1:0] s_addr;
    logic [7:0]       s_wdata;
    logic             s_wr, s_valid, s_halt, s_done;
    logic             r_out_v;
    logic [43:0]      r_out;

    bcc_cfg_regs #(.IrqVecInit(IrqVecInit)) u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_irq_vec(irq_vec)
    );

    bcc_divider u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    // a request steps the sequencer when the result slot is free and the divider is not running
    assign in_ch.ready = !r_out_v && !stall;
    assign step = in_ch.valid && in_ch.ready;

    bcc_sequencer u_seq (
        .i_clk, .i_rst_n, .i_step(step),
        .i_rd(in_ch.payload[7:0]), .i_irq(in_ch.payload[8]),
        .i_irq_vec(irq_vec), .i_div(div_rsp), .o_div(div_req), .o_stall(stall),
        .o_addr(s_addr), .o_wdata(s_wdata), .o_wr(s_wr), .o_valid(s_valid),
        .o_halted(s_halt), .o_done(s_done)
    );

    // result register; divider completion fills it too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((step && !div_req.start) || (stall && div_rsp.done)) begin
            r_out_v <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_v <= 1'b0;
        end
        if ((step && !div_req.start) || (stall && div_rsp.done)) begin
            r_out <= {s_done, s_halt, s_valid, s_wr, s_wdata, s_addr};
        end
    end

    assign out_ch.valid   = r_out_v;
    assign out_ch.payload = r_out;
endmodule

// ===== hdl/bcc_checker.sv =====
module bcc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [43:0] out_payload
);
`include "byte_cpu_bus_cycle_core_assert.svh"

    logic res_done, res_halt, res_acc, res_wr;

    assign res_done = out_payload[43];
    assign res_halt = out_payload[42];
    assign res_acc  = out_payload[41];
    assign res_wr   = out_payload[40];

    // no new request while a result waits
    `BCC_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, out_valid, !in_ready)
    // a halted result that ends no instruction is idle
    `BCC_ASSERT_IMP(a_halt_idle, i_clk, i_rst_n, out_valid && res_halt && !res_done, !res_acc)
    // a write is always a valid access
    `BCC_ASSERT_IMP(a_wr_valid, i_clk, i_rst_n, out_valid && res_wr, res_acc)
    // an accepted request yields a result or the divider stall
    `BCC_ASSERT_NEXT(a_accept_fill, i_clk, i_rst_n, in_valid && in_ready, out_valid || !in_ready)
endmodule

bind byte_cpu_bus_cycle_core bcc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
